/* hw/rtl/dcpt_pkg.sv */
// Shared types and constants for the delta-coded pair table decoder.
// No dependencies.
package dcpt_pkg;

  localparam logic [2:0] StRecord    = 3'd0;
  localparam logic [2:0] StBadFormat = 3'd1;
  localparam logic [2:0] StBadId     = 3'd2;
  localparam logic [2:0] StNegative  = 3'd3;
  localparam logic [2:0] StBadPtr    = 3'd4;

  localparam logic [3:0] PhFormat   = 4'd0;
  localparam logic [3:0] PhVersion  = 4'd1;
  localparam logic [3:0] PhNameLen  = 4'd2;
  localparam logic [3:0] PhNameSkip = 4'd3;
  localparam logic [3:0] PhPtrSize  = 4'd4;
  localparam logic [3:0] PhCount    = 4'd5;
  localparam logic [3:0] PhType     = 4'd6;
  localparam logic [3:0] PhId       = 4'd7;
  localparam logic [3:0] PhOffset   = 4'd8;
  localparam logic [3:0] PhDone     = 4'd9;

  // Job from the front end to the back end.
  typedef struct packed {
    logic        is_err;
    logic [2:0]  status;
    logic [63:0] id;
    logic [2:0]  off_code;
    logic        scaled;
    logic [63:0] off_val;
    logic [30:0] scale;
    logic        last;
    logic        fresh;
  } job_t;

  function automatic logic [3:0] code_bytes(input logic [2:0] code);
    logic [3:0] n;
    case (code)
      3'd0:    n = 4'd8;
      3'd1:    n = 4'd0;
      3'd2:    n = 4'd1;
      3'd3:    n = 4'd1;
      3'd4:    n = 4'd2;
      3'd5:    n = 4'd2;
      3'd6:    n = 4'd2;
      3'd7:    n = 4'd4;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [63:0] apply_code(input logic [2:0] code,
                                             input logic [63:0] base,
                                             input logic [63:0] v);
    logic [63:0] r;
    case (code)
      3'd1:      r = base + 64'd1;
      3'd2, 3'd4: r = base + v;
      3'd3, 3'd5: r = base - v;
      default:   r = v;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/dcpt_front.sv */
// Byte parser: header fields, record type bytes, id and offset fields.
// Depends on dcpt_pkg. Emits one job per record or error.
module dcpt_front import dcpt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       first_i,
  output logic       job_valid_o,
  input  logic       job_ready_i,
  output job_t       job_o
);

  logic [3:0]  phase_q, phase_d;
  logic [3:0]  idx_q, idx_d;
  logic [63:0] acc_q, acc_d;
  logic [30:0] skip_q, skip_d;
  logic [30:0] scale_q, scale_d;
  logic [30:0] recs_q, recs_d;
  logic [7:0]  type_q, type_d;
  logic [63:0] cur_id_q, cur_id_d;
  logic [63:0] prev_id_q, prev_id_d;
  logic        halt_q, halt_d;
  logic        fresh_q, fresh_d;
  logic        emit;
  job_t        job;

  assign in_ready_o  = job_ready_i;
  assign job_valid_o = in_valid_i && job_ready_i && emit;
  assign job_o       = job;

  always_comb begin
    logic [3:0]  ph, ix, need, nix;
    logic [63:0] ac, nac;
    logic [31:0] w;
    logic [30:0] rc;
    logic [2:0]  lo;
    ph = phase_q; ix = idx_q; ac = acc_q;
    skip_d = skip_q; scale_d = scale_q; recs_d = recs_q; type_d = type_q;
    cur_id_d = cur_id_q; prev_id_d = prev_id_q; halt_d = halt_q; fresh_d = fresh_q;
    emit = 1'b0;
    job = '0;
    need = 4'd4; nix = '0; nac = '0; w = '0; rc = '0; lo = '0;
    if (first_i) begin
      ph = PhFormat; ix = '0; ac = '0; skip_d = '0; scale_d = '0; recs_d = '0;
      type_d = '0; cur_id_d = '0; prev_id_d = '0; halt_d = 1'b0; fresh_d = 1'b1;
    end
    if (!halt_d && ph != PhDone) begin
      if (ph == PhVersion) begin
        ix = ix + 4'd1;
        if (ix == 4'd0) begin
          ph = PhNameLen; ac = '0;
        end
      end else if (ph == PhNameSkip) begin
        skip_d = skip_d - 31'd1;
        if (skip_d == '0) begin
          ph = PhPtrSize; ix = '0; ac = '0;
        end
      end else if (ph == PhType) begin
        type_d = data_byte_i;
        if (data_byte_i[3]) begin
          halt_d = 1'b1; emit = 1'b1; job.is_err = 1'b1; job.status = StBadId;
        end else begin
          lo = data_byte_i[2:0];
          ph = PhId; ix = '0; ac = '0;
          if (code_bytes(lo) == 4'd0) begin
            cur_id_d = apply_code(lo, prev_id_q, 64'd0);
            ph = PhOffset;
          end
        end
      end else if (ph <= PhOffset) begin
        nac = ac | ({56'd0, data_byte_i} << {ix[2:0], 3'b000});
        nix = ix + 4'd1;
        ac = nac; ix = nix;
        if (ph == PhId) need = code_bytes(type_d[2:0]);
        else if (ph == PhOffset) need = code_bytes(type_d[6:4]);
        if (nix >= need) begin
          w = nac[31:0];
          ix = '0; ac = '0;
          case (ph)
            PhFormat: begin
              if (w != 32'd1 && w != 32'd2) begin
                halt_d = 1'b1; emit = 1'b1; job.is_err = 1'b1;
                job.status = StBadFormat;
              end else ph = PhVersion;
            end
            PhNameLen: begin
              if (w[31]) begin
                halt_d = 1'b1; emit = 1'b1; job.is_err = 1'b1;
                job.status = StNegative;
              end else begin
                skip_d = w[30:0];
                ph = (w == '0) ? PhPtrSize : PhNameSkip;
              end
            end
            PhPtrSize: begin
              if (w == '0 || w[31]) begin
                halt_d = 1'b1; emit = 1'b1; job.is_err = 1'b1;
                job.status = StBadPtr;
              end else begin
                scale_d = w[30:0]; ph = PhCount;
              end
            end
            PhCount: begin
              if (w[31]) begin
                halt_d = 1'b1; emit = 1'b1; job.is_err = 1'b1;
                job.status = StNegative;
              end else begin
                recs_d = w[30:0];
                ph = (w == '0) ? PhDone : PhType;
              end
            end
            PhId: begin
              cur_id_d = apply_code(type_d[2:0], prev_id_q, nac);
              ph = PhOffset;
            end
            default: ph = PhOffset;
          endcase
          if (ph == PhOffset && !(phase_q == PhOffset && !first_i)) begin
            // offset field just opened; handled below
          end
        end
      end
      // Finish the record when the offset field needs no bytes or is complete.
      if (!emit && ph == PhOffset &&
          (code_bytes(type_d[6:4]) == 4'd0 ||
           (phase_q == PhOffset && !first_i && ix == '0))) begin
        rc = recs_d - 31'd1;
        emit = 1'b1;
        job.id = cur_id_d;
        job.off_code = type_d[6:4];
        job.scaled = type_d[7];
        job.off_val = nac;
        job.scale = scale_d;
        job.last = (rc == '0);
        job.fresh = fresh_d;
        fresh_d = 1'b0;
        recs_d = rc;
        prev_id_d = cur_id_d;
        ph = (rc == '0) ? PhDone : PhType;
      end
    end
    phase_d = ph; idx_d = ix; acc_d = ac;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFormat; idx_q <= '0; acc_q <= '0; skip_q <= '0;
      scale_q <= '0; recs_q <= '0; type_q <= '0; cur_id_q <= '0;
      prev_id_q <= '0; halt_q <= 1'b0; fresh_q <= 1'b1;
    end else if (in_valid_i && in_ready_o) begin
      phase_q <= phase_d; idx_q <= idx_d; acc_q <= acc_d; skip_q <= skip_d;
      scale_q <= scale_d; recs_q <= recs_d; type_q <= type_d;
      cur_id_q <= cur_id_d; prev_id_q <= prev_id_d; halt_q <= halt_d;
      fresh_q <= fresh_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_fires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o |-> in_valid_i && in_ready_o) else $error("job without byte");
  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o && job_o.is_err |=> halt_q) else $error("error did not halt");
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o && job_o.last && !job_o.is_err |=> phase_q == PhDone)
    else $error("last record not done");
`endif

endmodule

/* hw/rtl/dcpt_queue.sv */
// Two-entry job queue between parser and offset unit.
// Depends on dcpt_pkg.
module dcpt_queue import dcpt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  job_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output job_t rd_data_o
);

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count overflow");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> wp_q == rp_q) else $error("queue pointers");
  a_ptr_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd1 |-> wp_q != rp_q) else $error("queue pointers");
`endif

endmodule

/* hw/rtl/dcpt_back.sv */
// Offset unit: radix-16 divide and multiply by pointer size, output register.
// Depends on dcpt_pkg.
module dcpt_back import dcpt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  output logic        job_ready_o,
  input  job_t        job_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [63:0] id_o,
  output logic [63:0] offset_o,
  output logic        last_o
);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SDiv  = 2'd1;
  localparam logic [1:0] SMul  = 2'd2;

  logic [1:0]  st_q, st_d;
  logic [63:0] prev_off_q, prev_off_d;
  job_t        job_q;
  logic [63:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d;
  logic [3:0]  dig_q, dig_d;
  logic [63:0] base_q, base_d;
  logic [63:0] prod_q, prod_d;
  logic [1:0]  mstep_q, mstep_d;
  logic        ov_q, ov_d;
  logic [2:0]  ost_q, ost_d;
  logic [63:0] oid_q, oid_d, ooff_q, ooff_d;
  logic        olast_q, olast_d;
  logic        take;

  assign job_ready_o = st_q == SIdle && (!ov_q || out_ready_i);
  assign take = job_valid_i && job_ready_o;
  assign out_valid_o = ov_q;
  assign status_o = ost_q;
  assign id_o = oid_q;
  assign offset_o = ooff_q;
  assign last_o = olast_q;

  always_comb begin
    logic [35:0] r;
    logic [63:0] off;
    logic [47:0] pp;
    st_d = st_q; prev_off_d = prev_off_q; quo_d = quo_q; rem_d = rem_q;
    dig_d = dig_q; base_d = base_q; prod_d = prod_q; mstep_d = mstep_q;
    ov_d = ov_q && !out_ready_i;
    ost_d = ost_q; oid_d = oid_q; ooff_d = ooff_q; olast_d = olast_q;
    r = '0; off = '0; pp = '0;
    case (st_q)
      SIdle: begin
        if (take) begin
          if (job_i.is_err) begin
            ov_d = 1'b1; ost_d = job_i.status; oid_d = '0; ooff_d = '0; olast_d = 1'b0;
          end else if (job_i.scaled) begin
            quo_d = job_i.fresh ? 64'd0 : prev_off_q;
            rem_d = '0; dig_d = '0; st_d = SDiv;
          end else begin
            off = apply_code(job_i.off_code, job_i.fresh ? 64'd0 : prev_off_q,
                             job_i.off_val);
            prev_off_d = off;
            ov_d = 1'b1; ost_d = StRecord; oid_d = job_i.id; ooff_d = off;
            olast_d = job_i.last;
          end
        end
      end
      SDiv: begin
        // One quotient hex digit per cycle by restoring steps.
        r = {rem_q, quo_q[63:60]};
        for (int k = 0; k < 1; k++) begin end
        begin
          logic [35:0] t;
          logic [3:0]  q;
          t = r; q = '0;
          for (int b = 3; b >= 0; b--) begin
            if (t >= ({5'd0, job_q.scale} << b)) begin
              t = t - ({5'd0, job_q.scale} << b);
              q[b] = 1'b1;
            end
          end
          rem_d = t[31:0];
          quo_d = {quo_q[59:0], q};
        end
        dig_d = dig_q + 4'd1;
        if (dig_q == 4'd15) begin
          base_d = apply_code(job_q.off_code, {quo_q[59:0], quo_d[3:0]}, job_q.off_val);
          prod_d = '0; mstep_d = '0; st_d = SMul;
        end
      end
      SMul: begin
        // 16x31 partial product per cycle; last step waits while output is full.
        pp = {32'd0, base_q[{mstep_q, 4'b0000} +: 16]} * {17'd0, job_q.scale};
        prod_d = prod_q + ({16'd0, pp} << {mstep_q, 4'b0000});
        mstep_d = mstep_q + 2'd1;
        if (mstep_q == 2'd3) begin
          prev_off_d = prod_d;
          ov_d = 1'b1; ost_d = StRecord; oid_d = job_q.id; ooff_d = prod_d;
          olast_d = job_q.last; st_d = SIdle;
        end
      end
      default: st_d = SIdle;
    endcase
    if (st_q == SMul && mstep_q == 2'd3 && ov_q && !out_ready_i) begin
      st_d = SMul; mstep_d = mstep_q; prod_d = prod_q; prev_off_d = prev_off_q;
      ov_d = 1'b1; ost_d = ost_q; oid_d = oid_q; ooff_d = ooff_q; olast_d = olast_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) job_q <= job_i;
    quo_q <= quo_d; rem_q <= rem_d; base_q <= base_d; prod_q <= prod_d;
    ost_q <= ost_d; oid_q <= oid_d; ooff_q <= ooff_d; olast_q <= olast_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; prev_off_q <= '0; dig_q <= '0; mstep_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; prev_off_q <= prev_off_d; dig_q <= dig_d;
      mstep_q <= mstep_d; ov_q <= ov_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q && $stable(ooff_q)) else $error("result lost");
  a_div_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == SDiv && dig_q == 4'd15 |=> st_q == SMul) else $error("divider end");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != SIdle |-> !job_ready_o) else $error("busy take");
`endif

endmodule

/* hw/rtl/delta_coded_pair_table_decoder.sv */
// Delta-coded pair table decoder top level: parser, job queue, offset unit.
// A record's word passes from its last accepted byte through the job queue into
// the output register; a scaled record first runs the divide and multiply steps.
// Throughput: one byte per cycle while the queue has room; a scaled record keeps
// the offset unit from new jobs until done. Reset (rst_ni low, async) puts the parser at the
// format word and clears the queue. Depends on dcpt_pkg, dcpt_front, dcpt_queue, dcpt_back.
module delta_coded_pair_table_decoder import dcpt_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,  // [7:0] data_byte
  input  logic          s_axis_tuser,  // first
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [135:0]  m_axis_tdata,  // [2:0] status, [66:3] entry_id, [130:67] entry_offset
  output logic          m_axis_tlast   // last_entry
);

  logic f_valid, f_ready, b_valid, b_ready;
  job_t f_job, b_job;
  logic [2:0] st;
  logic [63:0] id, off;

  dcpt_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .data_byte_i(s_axis_tdata), .first_i(s_axis_tuser),
    .job_valid_o(f_valid), .job_ready_i(f_ready), .job_o(f_job)
  );

  dcpt_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_job),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(b_job)
  );

  dcpt_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(b_valid), .job_ready_o(b_ready), .job_i(b_job),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .status_o(st), .id_o(id), .offset_o(off), .last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, off, id, st};

endmodule

/* tb/tb.sv */
// Testbench for delta_coded_pair_table_decoder: streams table files byte by byte and
// checks each decoded id/offset word against a behavioral predictor in a scoreboard.
// Depends on dcpt_pkg and the decoder RTL.
module tb;
  import dcpt_pkg::*;

  typedef struct {
    logic [2:0]  status;
    logic [63:0] entry_id;
    logic [63:0] entry_offset;
    logic        last_entry;
  } pair_word_t;

  typedef struct {
    logic [7:0] data;
    logic       first;
  } file_byte_t;

  class pair_table_scoreboard;
    pair_word_t  expected_words[$];
    int          failures;
    logic [3:0]  phase;
    logic [3:0]  index;
    logic [63:0] acc;
    logic [30:0] skip_left;
    logic [30:0] ptr_scale;
    logic [30:0] recs_left;
    logic [7:0]  rec_type;
    logic [63:0] cur_id;
    logic [63:0] prev_id;
    logic [63:0] prev_off;
    logic        halted;

    function new();
      failures = 0;
      restart();
    endfunction

    function void restart();
      phase = PhFormat;
      index = '0;
      acc = '0;
      skip_left = '0;
      ptr_scale = '0;
      recs_left = '0;
      rec_type = '0;
      cur_id = '0;
      prev_id = '0;
      prev_off = '0;
      halted = 1'b0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function logic [3:0] field_len(logic [2:0] code);
      case (code)
        3'd0: return 4'd8;
        3'd1: return 4'd0;
        3'd2, 3'd3: return 4'd1;
        3'd7: return 4'd4;
        default: return 4'd2;
      endcase
    endfunction

    function logic [63:0] decode_value(logic [2:0] code, logic [63:0] base, logic [63:0] v);
      case (code)
        3'd1: return base + 64'd1;
        3'd2, 3'd4: return base + v;
        3'd3, 3'd5: return base - v;
        default: return v;
      endcase
    endfunction

    function void push_word(logic [2:0] st, logic [63:0] id, logic [63:0] off, logic last);
      pair_word_t w;
      w.status = st;
      w.entry_id = id;
      w.entry_offset = off;
      w.last_entry = last;
      expected_words.push_back(w);
    endfunction

    function void flag_error(logic [2:0] st);
      halted = 1'b1;
      push_word(st, '0, '0, 1'b0);
    endfunction

    function void open_field(logic [3:0] ph);
      phase = ph;
      index = '0;
      acc = '0;
    endfunction

    function void close_record();
      logic [63:0] base;
      logic [63:0] off;
      logic        last;
      base = prev_off;
      if (rec_type[7] && ptr_scale != '0) base = prev_off / {33'd0, ptr_scale};
      off = decode_value(rec_type[6:4], base, acc);
      if (rec_type[7]) off = off * {33'd0, ptr_scale};
      prev_id = cur_id;
      prev_off = off;
      recs_left = recs_left - 31'd1;
      last = (recs_left == '0);
      phase = last ? PhDone : PhType;
      push_word(StRecord, cur_id, off, last);
    endfunction

    function void open_offset();
      open_field(PhOffset);
      if (field_len(rec_type[6:4]) == '0) close_record();
    endfunction

    function void note_byte(logic [7:0] b, logic f);
      logic [3:0]  need;
      logic [31:0] w;
      if (f) restart();
      if (halted || phase == PhDone) return;
      if (phase == PhVersion) begin
        index = index + 4'd1;
        if (index == '0) open_field(PhNameLen);
        return;
      end
      if (phase == PhNameSkip) begin
        skip_left = skip_left - 31'd1;
        if (skip_left == '0) open_field(PhPtrSize);
        return;
      end
      if (phase == PhType) begin
        rec_type = b;
        if (b[3]) begin
          flag_error(StBadId);
          return;
        end
        open_field(PhId);
        if (field_len(b[2:0]) == '0) begin
          cur_id = decode_value(b[2:0], prev_id, '0);
          open_offset();
        end
        return;
      end
      if (phase > PhOffset) return;
      acc = acc | ({56'd0, b} << (8 * index[2:0]));
      index = index + 4'd1;
      if (phase == PhId) need = field_len(rec_type[2:0]);
      else if (phase == PhOffset) need = field_len(rec_type[6:4]);
      else need = 4'd4;
      if (index < need) return;
      w = acc[31:0];
      case (phase)
        PhFormat: begin
          if (w != 32'd1 && w != 32'd2) flag_error(StBadFormat);
          else open_field(PhVersion);
        end
        PhNameLen: begin
          if (w[31]) flag_error(StNegative);
          else begin
            skip_left = w[30:0];
            open_field(w == '0 ? PhPtrSize : PhNameSkip);
          end
        end
        PhPtrSize: begin
          if (w == '0 || w[31]) flag_error(StBadPtr);
          else begin
            ptr_scale = w[30:0];
            open_field(PhCount);
          end
        end
        PhCount: begin
          if (w[31]) flag_error(StNegative);
          else begin
            recs_left = w[30:0];
            open_field(w == '0 ? PhDone : PhType);
          end
        end
        PhId: begin
          cur_id = decode_value(rec_type[2:0], prev_id, acc);
          open_offset();
        end
        default: close_record();
      endcase
    endfunction

    function void check_word(logic [135:0] d, logic last);
      pair_word_t e;
      if (expected_words.size() == 0) begin
        $error("unexpected word: status %0d id %h offset %h", d[2:0], d[66:3], d[130:67]);
        failures++;
        return;
      end
      e = expected_words.pop_front();
      if (d[2:0] !== e.status) begin
        $error("status: expected %0d actual %0d", e.status, d[2:0]);
        failures++;
      end
      if (d[66:3] !== e.entry_id) begin
        $error("entry_id: expected %h actual %h", e.entry_id, d[66:3]);
        failures++;
      end
      if (d[130:67] !== e.entry_offset) begin
        $error("entry_offset: expected %h actual %h", e.entry_offset, d[130:67]);
        failures++;
      end
      if (last !== e.last_entry) begin
        $error("last_entry: expected %0d actual %0d", e.last_entry, last);
        failures++;
      end
      if (d[135:131] !== 5'd0) begin
        $error("padding: expected 0 actual %h", d[135:131]);
        failures++;
      end
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [135:0] m_axis_tdata;
  logic         m_axis_tlast;

  pair_table_scoreboard sb;
  file_byte_t           stream[$];
  int                   send_idle;
  int                   recv_stall;
  int                   quiet_cycles;

  delta_coded_pair_table_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    send_idle = 0;
    recv_stall = 0;
    quiet_cycles = 0;
    sb = new();
  end

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tlast);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= 5000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic logic [7:0] field_byte();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic f);
    file_byte_t fb;
    fb.data = b;
    fb.first = f;
    stream.push_back(fb);
  endtask

  task automatic put_word32(input logic [31:0] w);
    for (int i = 0; i < 4; i++) put_byte(w[8*i +: 8], 1'b0);
  endtask

  // mode 0: random record types, mode 1: sweep every id and offset code
  task automatic put_file(input logic mark, input logic [31:0] fmt, input logic [31:0] name_len,
                          input logic [31:0] ptr, input logic [31:0] count, input int nrec,
                          input int bad_at, input int mode);
    logic [7:0] t;
    int         n;
    put_byte(fmt[7:0], mark);
    put_byte(fmt[15:8], 1'b0);
    put_byte(fmt[23:16], 1'b0);
    put_byte(fmt[31:24], 1'b0);
    for (int i = 0; i < 4; i++) put_word32($urandom);
    put_word32(name_len);
    if (!name_len[31]) for (int i = 0; i < name_len; i++) put_byte(8'($urandom), 1'b0);
    put_word32(ptr);
    put_word32(count);
    for (int r = 0; r < nrec; r++) begin
      if (mode == 1) t = {4'(r), 1'b0, 3'(r)};
      else t = {4'($urandom_range(15)), 1'b0, 3'($urandom_range(7))};
      if (r == bad_at) t[3] = 1'b1;
      t[2] = t[2] | (r == bad_at && $urandom_range(1) == 1);
      put_byte(t, 1'b0);
      if (r == bad_at) break;
      n = (t[2:0] == 3'd0) ? 8 : (t[2:0] == 3'd1) ? 0 : (t[2:0] < 3'd4) ? 1 :
          (t[2:0] == 3'd7) ? 4 : 2;
      for (int i = 0; i < n; i++) put_byte(field_byte(), 1'b0);
      n = (t[6:4] == 3'd0) ? 8 : (t[6:4] == 3'd1) ? 0 : (t[6:4] < 3'd4) ? 1 :
          (t[6:4] == 3'd7) ? 4 : 2;
      for (int i = 0; i < n; i++) put_byte(field_byte(), 1'b0);
    end
  endtask

  function automatic logic [31:0] pick_ptr();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'($urandom_range(32'h7FFF_FFFF, 1));
      default: return 32'($urandom_range(16, 1));
    endcase
  endfunction

  task automatic build_stream();
    int c;
    int k;
    put_file(1'b0, 32'd1, 32'd0, 32'd8, 32'd2, 2, -1, 0);
    put_file(1'b1, 32'd3, 32'd0, 32'd8, 32'd1, 1, -1, 0);
    put_byte(8'hA5, 1'b0);
    put_file(1'b1, 32'd2, 32'h8000_0000, 32'd8, 32'd1, 0, -1, 0);
    put_file(1'b1, 32'd1, 32'd3, 32'd0, 32'd1, 0, -1, 0);
    put_file(1'b1, 32'd2, 32'd1, 32'hFFFF_FFFF, 32'd1, 0, -1, 0);
    put_file(1'b1, 32'd1, 32'd0, 32'd4, 32'hFFFF_FFFF, 0, -1, 0);
    put_file(1'b1, 32'd1, 32'd2, 32'd4, 32'd0, 2, -1, 0);
    put_file(1'b1, 32'd1, 32'd0, 32'd8, 32'd4, 4, 2, 0);
    put_file(1'b1, 32'd2, 32'd0, 32'd8, 32'd16, 16, -1, 1);
    put_file(1'b1, 32'd1, 32'd0, 32'h7FFF_FFFF, 32'd16, 16, -1, 1);
    put_file(1'b1, 32'd1, 32'd0, 32'd3, 32'd5, 2, -1, 0);
    while (stream.size() < 1150) begin
      k = $urandom_range(99);
      c = $urandom_range(6, 1);
      if (k < 70) begin
        put_file(1'b1, 32'($urandom_range(2, 1)), 32'($urandom_range(6)), pick_ptr(),
                 32'(c), c, -1, 0);
      end else if (k < 78) begin
        put_file(1'b1, 32'd1, 32'd0, pick_ptr(), 32'(c), c, $urandom_range(c - 1), 0);
      end else if (k < 84) begin
        put_file(1'b1, 32'd2, 32'd1, pick_ptr(), 32'(c + 2), c, -1, 0);
      end else if (k < 90) begin
        put_file(1'b1, $urandom, {1'($urandom_range(1)), 31'($urandom_range(6))},
                 $urandom, $urandom, c, -1, 0);
      end else if (k < 95) begin
        put_file(1'b1, 32'd1, 32'd0, pick_ptr(), 32'(c), c, -1, 0);
        repeat ($urandom_range(5)) put_byte(8'($urandom), 1'b0);
      end else begin
        repeat ($urandom_range(8, 1)) put_byte(8'($urandom), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic f);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= f;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  initial begin
    int total;
    build_stream();
    total = stream.size();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < total; i++) begin
      case ((i * 4) / total)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 80; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 80; end
        default: begin send_idle = 14; recv_stall = 14; end
      endcase
      if (i == total / 2) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (sb.pending() != 0) @(posedge clk_i);
        repeat (30) @(posedge clk_i);
      end
      send_byte(stream[i].data, stream[i].first);
    end
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
